FILE: hdl/hbsd_pkg.sv
// shared types and constants of the bit-serial huffman decoder
package hbsd_pkg;

  localparam int DEF_ENTRIES   = 256;
  localparam int DEF_CODE_BITS = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam int OP_W    = 2;
  localparam int INDEX_W = 8;
  localparam int WORD_W  = 32;
  localparam int LEN_W   = 6;
  localparam int CFG_W   = 9;
  localparam int REG_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET    = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

  localparam logic [REG_W-1:0] REG_MAX_LENGTH = 2'd0;
  localparam logic [REG_W-1:0] REG_CODE_COUNT = 2'd1;
  localparam logic [REG_W-1:0] REG_BIT_ORDER  = 2'd2;

  localparam logic STATUS_FOUND   = 1'b0;
  localparam logic STATUS_UNKNOWN = 1'b1;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 6'd32;
  localparam logic [CFG_W-1:0] CODE_COUNT_RESET = 9'd256;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  code;
    logic [LEN_W-1:0]   length;
    logic [WORD_W-1:0]  symbol;
    logic               bit_val;
  } hbsd_item_t;

endpackage

FILE: hdl/hbsd_front.sv
// request intake: drops requests with no effect and queues the rest
module hbsd_front
  import hbsd_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [OP_W-1:0]    opcode,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [WORD_W-1:0]  entry_code,
  input  logic [LEN_W-1:0]   entry_length,
  input  logic [WORD_W-1:0]  entry_symbol,
  input  logic               bit_in,
  output logic               busy,
  output logic               head_valid,
  output hbsd_item_t         head,
  input  logic               pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hbsd_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             keep;
  logic             push;
  hbsd_item_t       item;

  // table writes beyond the table and the unused opcode have no effect
  always_comb begin
    case (opcode)
      OP_LOAD, OP_SET: keep = (32'(entry_index) < ENTRIES);
      OP_DECODE:       keep = 1'b1;
      default:         keep = 1'b0;
    endcase
  end

  assign busy       = (count == CNT_W'(QUEUE_DEPTH));
  assign push       = start && !busy && keep;
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_comb begin
    item.op      = opcode;
    item.index   = entry_index;
    item.code    = entry_code;
    item.length  = entry_length;
    item.symbol  = entry_symbol;
    item.bit_val = bit_in;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

FILE: hdl/hbsd_back.sv
// table memories, running code and the sequential table scan
module hbsd_back
  import hbsd_pkg::*;
#(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int CODE_BITS = DEF_CODE_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [REG_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              head_valid,
  input  hbsd_item_t        head,
  output logic              pop,
  output logic              result_valid,
  output logic [WORD_W-1:0] symbol_out,
  output logic              status
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic [CODE_BITS-1:0] code_mem [ENTRIES];
  logic [LEN_W-1:0]     len_mem  [ENTRIES];
  logic [WORD_W-1:0]    sym_mem  [ENTRIES];

  logic [LEN_W-1:0]     max_length;
  logic [CFG_W-1:0]     code_count;
  logic                 bit_order;

  logic                 state;
  logic [CODE_BITS-1:0] acc;
  logic [CODE_BITS-1:0] acc_next;
  logic [LEN_W-1:0]     bits_taken;
  logic [LEN_W-1:0]     bits_next;
  logic [CNT_W-1:0]     scan_idx;
  logic                 cmp_valid;
  logic [CODE_BITS-1:0] code_q;
  logic [LEN_W-1:0]     len_q;
  logic [WORD_W-1:0]    sym_q;

  logic [CNT_W-1:0]     used;
  logic [LEN_W-1:0]     limit;
  logic [IDX_W-1:0]     wr_addr;
  logic                 rd_en;
  logic                 match;
  logic                 is_decode;

  always_comb begin
    used  = (32'(code_count) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(code_count);
    limit = (32'(max_length) > CODE_BITS) ? LEN_W'(CODE_BITS) : max_length;
  end

  assign pop       = (state == S_IDLE) && head_valid;
  assign is_decode = (head.op == OP_DECODE);
  assign wr_addr   = IDX_W'(head.index);
  assign rd_en     = (state == S_SCAN) && (scan_idx < used);
  assign match     = cmp_valid && (len_q == bits_taken) && (code_q == acc);

  always_comb begin
    bits_next = bits_taken + 1'b1;
    if (bit_order) begin
      acc_next = acc | (CODE_BITS'(head.bit_val) << bits_taken);
    end else begin
      acc_next = (acc << 1) | CODE_BITS'(head.bit_val);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !is_decode) begin
      if (head.op == OP_LOAD) begin
        code_mem[wr_addr] <= head.code[CODE_BITS-1:0];
        len_mem[wr_addr]  <= head.length;
      end
      sym_mem[wr_addr] <= head.symbol;
    end
    if (rd_en) begin
      code_q <= code_mem[scan_idx[IDX_W-1:0]];
      len_q  <= len_mem[scan_idx[IDX_W-1:0]];
      sym_q  <= sym_mem[scan_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
      code_count <= CODE_COUNT_RESET;
      bit_order  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_LENGTH: max_length <= cfg_data[LEN_W-1:0];
        REG_CODE_COUNT: code_count <= cfg_data;
        REG_BIT_ORDER:  bit_order  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      acc          <= '0;
      bits_taken   <= '0;
      scan_idx     <= '0;
      cmp_valid    <= 1'b0;
      result_valid <= 1'b0;
      symbol_out   <= '0;
      status       <= STATUS_FOUND;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop && is_decode) begin
            acc        <= acc_next;
            bits_taken <= bits_next;
            scan_idx   <= '0;
            cmp_valid  <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            result_valid <= 1'b1;
            symbol_out   <= sym_q;
            status       <= STATUS_FOUND;
            acc          <= '0;
            bits_taken   <= '0;
            cmp_valid    <= 1'b0;
            state        <= S_IDLE;
          end else if (rd_en) begin
            scan_idx  <= scan_idx + 1'b1;
            cmp_valid <= 1'b1;
          end else if (cmp_valid) begin
            // last entry read has been compared without a hit
            cmp_valid <= 1'b0;
          end else begin
            // table exhausted with no hit
            if (bits_taken >= limit) begin
              result_valid <= 1'b1;
              symbol_out   <= '0;
              status       <= STATUS_UNKNOWN;
              acc          <= '0;
              bits_taken   <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe lasted more than one cycle");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == STATUS_UNKNOWN) |-> (symbol_out == '0))
    else $error("unknown-code result carries a symbol");

  a_bits_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (32'(bits_taken) < CODE_BITS))
    else $error("running code kept at full width");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= used))
    else $error("scan index ran past the table");

  a_result_cleared: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (bits_taken == '0 && acc == '0))
    else $error("running code not cleared after a result");

endmodule

FILE: hdl/huffman_bit_serial_decoder_top.sv
// top level of the table-driven bit-serial huffman decoder
//
//  channel   handshake           payload
//  request   start / busy        opcode, entry_index, entry_code, entry_length,
//                                entry_symbol, bit_in
//  result    result_valid        symbol_out, status
//  config    cfg_write           cfg_index, cfg_data
//
// a load or set-symbol request is written into the tables when the table unit takes it from the queue
// a decode request scans entries 0 to min(code_count, ENTRIES) - 1 and stops at the first hit;
// the table is read one entry per cycle
// busy rises only when the two-deep request queue is full
// reset clears the queue and the running code and returns the registers to their reset values; tables keep garbage
// result_valid is a one-cycle strobe and cannot be held off
module huffman_bit_serial_decoder_top
  import hbsd_pkg::*;
#(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int CODE_BITS = DEF_CODE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    opcode,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [WORD_W-1:0]  entry_code,
  input  logic [LEN_W-1:0]   entry_length,
  input  logic [WORD_W-1:0]  entry_symbol,
  input  logic               bit_in,
  input  logic               cfg_write,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               result_valid,
  output logic [WORD_W-1:0]  symbol_out,
  output logic               status
);

  logic       head_valid;
  logic       pop;
  hbsd_item_t head;

  hbsd_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .opcode       (opcode),
    .entry_index  (entry_index),
    .entry_code   (entry_code),
    .entry_length (entry_length),
    .entry_symbol (entry_symbol),
    .bit_in       (bit_in),
    .busy         (busy),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop)
  );

  hbsd_back #(
    .ENTRIES   (ENTRIES),
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .symbol_out   (symbol_out),
    .status       (status)
  );

endmodule

FILE: dv/hbsd_checker.sv
// checker for the bit-serial huffman decoder: predicts decode results and compares them
`timescale 1ns / 1ps
module hbsd_checker
  import hbsd_pkg::*;
#(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int CODE_BITS = DEF_CODE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [OP_W-1:0]    opcode,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [WORD_W-1:0]  entry_code,
  input  logic [LEN_W-1:0]   entry_length,
  input  logic [WORD_W-1:0]  entry_symbol,
  input  logic               bit_in,
  input  logic               cfg_write,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               result_valid,
  input  logic [WORD_W-1:0]  symbol_out,
  input  logic               status,
  output int                 fail_count,
  output int                 pending,
  output int                 symbols_found,
  output int                 unknown_codes
);

  localparam logic [WORD_W-1:0] CODE_MASK = WORD_W'((64'd1 << CODE_BITS) - 1);

  typedef struct packed {
    logic [WORD_W-1:0] symbol;
    logic              status;
  } decode_result_t;

  logic [WORD_W-1:0] code_mem [ENTRIES];
  logic [LEN_W-1:0]  len_mem  [ENTRIES];
  logic [WORD_W-1:0] sym_mem  [ENTRIES];
  logic [WORD_W-1:0] run_code;
  int unsigned       run_bits;
  logic [LEN_W-1:0]  max_len_q;
  logic [CFG_W-1:0]  count_q;
  logic              order_q;
  decode_result_t    expected_decodes[$];
  decode_result_t    want;
  int                fails;
  int                found_seen;
  int                unknown_seen;

  task automatic flag(input string what, input logic [WORD_W-1:0] exp_val,
                      input logic [WORD_W-1:0] got_val);
    fails++;
    if (fails <= 40)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_val, got_val);
  endtask

  // append one stream bit to the running code; predict a table hit or an unknown code
  task automatic take_stream_bit(input logic b);
    int unsigned    limit;
    int unsigned    used;
    bit             hit;
    decode_result_t r;
    limit = (max_len_q > CODE_BITS) ? CODE_BITS : max_len_q;
    used  = (count_q > ENTRIES) ? ENTRIES : count_q;
    if (order_q == 1'b0)
      run_code = ((run_code << 1) | WORD_W'(b)) & CODE_MASK;
    else
      run_code = (run_code | (WORD_W'(b) << run_bits)) & CODE_MASK;
    run_bits++;
    hit = 1'b0;
    r   = '0;
    for (int i = 0; i < used && !hit; i++) begin
      if (len_mem[i] == run_bits && code_mem[i] == run_code) begin
        hit      = 1'b1;
        r.symbol = sym_mem[i];
        r.status = STATUS_FOUND;
      end
    end
    if (!hit && run_bits >= limit) begin
      hit      = 1'b1;
      r.symbol = '0;
      r.status = STATUS_UNKNOWN;
    end
    if (hit) begin
      expected_decodes = {expected_decodes, r};
      run_code = '0;
      run_bits = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        code_mem[i] = '0;
        len_mem[i]  = '0;
        sym_mem[i]  = '0;
      end
      run_code  = '0;
      run_bits  = 0;
      max_len_q = MAX_LENGTH_RESET;
      count_q   = CODE_COUNT_RESET;
      order_q   = 1'b0;
      expected_decodes.delete();
    end else begin
      if (result_valid) begin
        if (status == STATUS_FOUND) found_seen++;
        else unknown_seen++;
        if (expected_decodes.size() == 0) begin
          fails++;
          if (fails <= 40)
            $display("%0t: result with nothing expected, expected none, actual %h status %0d",
                     $time, symbol_out, status);
        end else begin
          want = expected_decodes.pop_front();
          if (status !== want.status) flag("status", WORD_W'(want.status), WORD_W'(status));
          if (symbol_out !== want.symbol) flag("symbol_out", want.symbol, symbol_out);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_MAX_LENGTH: max_len_q = cfg_data[LEN_W-1:0];
          REG_CODE_COUNT: count_q   = cfg_data;
          REG_BIT_ORDER:  order_q   = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (opcode)
          OP_LOAD, OP_SET: begin
            if (entry_index < ENTRIES) begin
              if (opcode == OP_LOAD) begin
                code_mem[entry_index] = entry_code & CODE_MASK;
                len_mem[entry_index]  = entry_length;
              end
              sym_mem[entry_index] = entry_symbol;
            end
          end
          OP_DECODE: take_stream_bit(bit_in);
          default: ;
        endcase
      end
    end
    fail_count    <= fails;
    pending       <= expected_decodes.size();
    symbols_found <= found_seen;
    unknown_codes <= unknown_seen;
  end

endmodule

FILE: dv/huffman_bit_serial_decoder_top_tb.sv
// testbench top: drives table loads and sets, decode bits, unused opcodes, register writes
`timescale 1ns / 1ps
module huffman_bit_serial_decoder_top_tb;
  import hbsd_pkg::*;

  localparam int ITEM_TARGET = 1350;
  localparam int CALM_TAIL   = 120;
  localparam int TIMEOUT_NS  = 30_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    opcode;
  logic [INDEX_W-1:0] entry_index;
  logic [WORD_W-1:0]  entry_code;
  logic [LEN_W-1:0]   entry_length;
  logic [WORD_W-1:0]  entry_symbol;
  logic               bit_in;
  logic               cfg_write;
  logic [REG_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               result_valid;
  logic [WORD_W-1:0]  symbol_out;
  logic               status;

  int fail_count;
  int pending;
  int symbols_found;
  int unknown_codes;

  // local copy of the table, so bit streams can be built from real code words
  logic [WORD_W-1:0] tbl_code [DEF_ENTRIES];
  logic [LEN_W-1:0]  tbl_len  [DEF_ENTRIES];
  bit                loaded   [DEF_ENTRIES];
  logic [CFG_W-1:0]  cur_count;
  logic              cur_order;
  int                items_sent;
  int                decode_bits;
  int                settings;
  int                gap_pct;
  int                phase;

  huffman_bit_serial_decoder_top DUT (.*);

  hbsd_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .entry_index(entry_index), .entry_code(entry_code), .entry_length(entry_length),
    .entry_symbol(entry_symbol), .bit_in(bit_in), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
    .symbol_out(symbol_out), .status(status), .fail_count(fail_count),
    .pending(pending), .symbols_found(symbols_found), .unknown_codes(unknown_codes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("huffman_bit_serial_decoder_top_tb NOT OK");
    $finish;
  end

  function automatic logic [WORD_W-1:0] low_bits(input int len);
    return (len >= WORD_W) ? '1 : WORD_W'((64'd1 << len) - 1);
  endfunction

  function automatic int effective_count();
    return (cur_count > DEF_ENTRIES) ? DEF_ENTRIES : int'(cur_count);
  endfunction

  // an entry whose bits can actually be sent as a code word
  function automatic bit usable(input int i);
    return tbl_len[i] >= 1 && tbl_len[i] <= WORD_W && (tbl_code[i] & ~low_bits(tbl_len[i])) == 0;
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                              input logic [WORD_W-1:0] code, input logic [LEN_W-1:0] len,
                              input logic [WORD_W-1:0] sym, input logic b);
    int n;
    if (items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(99) < gap_pct) begin
      n = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
    start        <= 1'b1;
    opcode       <= op;
    entry_index  <= idx;
    entry_code   <= code;
    entry_length <= len;
    entry_symbol <= sym;
    bit_in       <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_decode(input logic b);
    send_request(OP_DECODE, INDEX_W'($urandom()), $urandom(), LEN_W'($urandom()),
                 $urandom(), b);
    decode_bits++;
  endtask

  task automatic load_entry(input int idx, input logic [WORD_W-1:0] code,
                            input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] sym);
    tbl_code[idx] = code;
    tbl_len[idx]  = len;
    loaded[idx]   = 1'b1;
    send_request(OP_LOAD, INDEX_W'(idx), code, len, sym, 1'($urandom()));
  endtask

  task automatic emit_codeword(input int idx);
    for (int k = 0; k < tbl_len[idx]; k++)
      send_decode(cur_order ? tbl_code[idx][k] : tbl_code[idx][tbl_len[idx] - 1 - k]);
  endtask

  task automatic set_registers(input logic [LEN_W-1:0] ml, input logic [CFG_W-1:0] cc,
                               input logic ord);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_LENGTH;
    cfg_data  <= CFG_W'(ml);
    @(posedge clk);
    cfg_index <= REG_CODE_COUNT;
    cfg_data  <= cc;
    @(posedge clk);
    cfg_index <= REG_BIT_ORDER;
    cfg_data  <= CFG_W'(ord);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_count   = cc;
    cur_order   = ord;
    settings++;
  endtask

  // wait for the last result, then give a full queue of table scans time to finish
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3 * (effective_count() + 4) + 8) @(posedge clk);
  endtask

  task automatic build_table(input int n);
    int                style;
    int                flen;
    int                roll;
    logic [WORD_W-1:0] fmask;
    logic [WORD_W-1:0] code;
    logic [LEN_W-1:0]  len;
    style = $urandom_range(2);
    flen  = ((n > 1) ? $clog2(n) : 1) + $urandom_range(3);
    fmask = $urandom();
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(15);
      if (roll == 0) begin
        // zero or oversize length: never matches
        len  = ($urandom_range(1) == 0) ? '0 : LEN_W'($urandom_range(33, 63));
        code = $urandom();
      end else if (roll == 1) begin
        // code bits above the length: cannot match either
        len  = LEN_W'($urandom_range(1, 31));
        code = $urandom() | (32'h1 << len);
      end else begin
        case (style)
          0: begin
            // fixed-length prefix-free code
            len  = LEN_W'(flen);
            code = (WORD_W'(i) ^ fmask) & low_bits(flen);
          end
          1: begin
            len  = LEN_W'($urandom_range(1, 6));
            code = $urandom() & low_bits(len);
          end
          default: begin
            len  = LEN_W'($urandom_range(1, 32));
            code = $urandom() & low_bits(len);
          end
        endcase
      end
      load_entry(i, code, len, $urandom());
    end
  endtask

  task automatic run_stream(input int units);
    int               used;
    int               roll;
    int               pick;
    int               tries;
    logic [LEN_W-1:0] len;
    used = effective_count();
    for (int u = 0; u < units && items_sent < ITEM_TARGET; u++) begin
      roll = $urandom_range(99);
      pick = (used > 0) ? $urandom_range(used - 1) : $urandom_range(255);
      if (roll < 78) begin
        tries = 0;
        while (tries < 8 && !(used > 0 && usable(pick))) begin
          pick = (used > 0) ? $urandom_range(used - 1) : 0;
          tries++;
        end
        if (used > 0 && usable(pick)) emit_codeword(pick);
        else send_decode(1'($urandom()));
      end else if (roll < 86) begin
        send_decode(1'($urandom()));
      end else if (roll < 91) begin
        send_request(OP_SET, INDEX_W'(pick), $urandom(), LEN_W'($urandom()), $urandom(),
                     1'($urandom()));
      end else if (roll < 95) begin
        if ($urandom_range(1) == 0 && loaded[pick]) begin
          load_entry(pick, tbl_code[pick], tbl_len[pick], $urandom());
        end else begin
          len = LEN_W'($urandom_range(1, 6));
          load_entry(pick, $urandom() & low_bits(len), len, $urandom());
        end
      end else if (roll < 98) begin
        send_request(OP_UNUSED, INDEX_W'($urandom()), $urandom(), LEN_W'($urandom()),
                     $urandom(), 1'($urandom()));
      end else if (used < DEF_ENTRIES) begin
        // entry above the count in use: stored but not looked up
        len = LEN_W'($urandom_range(1, 6));
        load_entry($urandom_range(used, DEF_ENTRIES - 1), $urandom() & low_bits(len), len,
                   $urandom());
      end
    end
    // leave a partial code behind now and then across the next register writes
    repeat ($urandom_range(3)) send_decode(1'($urandom()));
  endtask

  task automatic run_phase(input int p);
    int               roll;
    int               used;
    bit               fresh;
    logic [LEN_W-1:0] ml;
    logic [CFG_W-1:0] cc;
    logic             ord;
    ord = 1'($urandom());
    case (p)
      0: begin
        cc  = CFG_W'(256);
        ml  = LEN_W'(32);
        ord = 1'b0;
      end
      1: begin
        cc  = '1;
        ml  = '1;
        ord = 1'b1;
      end
      2: begin
        cc = CFG_W'(1);
        ml = LEN_W'(1);
      end
      default: begin
        roll = $urandom_range(19);
        if (roll == 0) cc = '0;
        else if (roll == 1) cc = CFG_W'(256);
        else if (roll == 2) cc = CFG_W'($urandom_range(257, 511));
        else if (roll < 6) cc = CFG_W'($urandom_range(17, 64));
        else cc = CFG_W'($urandom_range(1, 16));
        roll = $urandom_range(9);
        case (roll)
          0: ml = '0;
          1: ml = LEN_W'($urandom_range(33, 63));
          2: ml = LEN_W'($urandom_range(1, 3));
          3: ml = LEN_W'(32);
          default: ml = LEN_W'($urandom_range(6, 32));
        endcase
      end
    endcase
    settle();
    set_registers(ml, cc, ord);
    used  = effective_count();
    fresh = (used <= 64 && $urandom_range(3) != 0);
    for (int i = 0; i < used; i++)
      if (!loaded[i]) fresh = 1'b1;
    gap_pct = ($urandom_range(3) == 0) ? 0 : 25;
    if (fresh) build_table(used);
    run_stream($urandom_range(10, 30));
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = OP_LOAD;
    entry_index  = '0;
    entry_code   = '0;
    entry_length = '0;
    entry_symbol = '0;
    bit_in       = 1'b0;
    cfg_write    = 1'b0;
    cfg_index    = REG_MAX_LENGTH;
    cfg_data     = '0;
    cur_count    = CODE_COUNT_RESET;
    cur_order    = 1'b0;
    items_sent   = 0;
    decode_bits  = 0;
    settings     = 0;
    gap_pct      = 20;
    for (int i = 0; i < DEF_ENTRIES; i++) loaded[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short code table with an all-ones 32-bit word and an oversize length
    set_registers(LEN_W'(3), CFG_W'(4), 1'b0);
    load_entry(0, 32'h0, LEN_W'(1), 32'hFFFF_FFFF);
    load_entry(1, 32'hFFFF_FFFF, LEN_W'(32), 32'h0);
    load_entry(2, 32'h2, LEN_W'(2), 32'hA5A5_A5A5);
    load_entry(3, 32'h7, LEN_W'(63), 32'h1);
    send_request(OP_SET, INDEX_W'(2), 32'h0, '0, 32'h5A5A_5A5A, 1'b0);
    send_request(OP_UNUSED, '1, '1, '1, '1, 1'b1);
    send_decode(1'b0);
    send_decode(1'b1);
    send_decode(1'b0);
    repeat (3) send_decode(1'b1);
    // zero max length: first bit either hits or is unknown
    settle();
    set_registers('0, CFG_W'(4), 1'b1);
    send_decode(1'b0);
    send_decode(1'b1);
    // empty table: every code is unknown
    settle();
    set_registers(LEN_W'(2), '0, 1'b1);
    send_decode(1'b1);
    send_decode(1'b0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase);
      phase++;
    end
    settle();

    $display("covered %0d requests (%0d decode bits) over %0d register settings",
             items_sent, decode_bits, settings);
    $display("decoder returned %0d symbols and %0d unknown-code reports",
             symbols_found, unknown_codes);
    if (pending != 0)
      $display("%0t: %0d decode results expected but never returned", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("huffman_bit_serial_decoder_top_tb OK");
    end else begin
      $display("huffman_bit_serial_decoder_top_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hbsd_pkg.sv
hdl/hbsd_front.sv
hdl/hbsd_back.sv
hdl/huffman_bit_serial_decoder_top.sv
dv/hbsd_checker.sv
dv/huffman_bit_serial_decoder_top_tb.sv
